@@ rtl/cqdbv_pkg.sv @@
// Shared types and constants for the circular queue with delete by value
`default_nettype none
package cqdbv_pkg;

    localparam int DEPTH  = 32;
    localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW     = $clog2(DEPTH + 1);
    localparam int DATA_W = 32;

    localparam logic [1:0] OP_ENQ    = 2'd0;
    localparam logic [1:0] OP_REMOVE = 2'd1;
    localparam logic [1:0] OP_LIST   = 2'd2;
    localparam logic [1:0] OP_NONE   = 2'd3;

    localparam logic [2:0] ST_STORED   = 3'd0;
    localparam logic [2:0] ST_FULL     = 3'd1;
    localparam logic [2:0] ST_REMOVED  = 3'd2;
    localparam logic [2:0] ST_NOTFOUND = 3'd3;
    localparam logic [2:0] ST_EMPTY    = 3'd4;
    localparam logic [2:0] ST_LISTED   = 3'd5;

    typedef struct packed {
        logic [1:0]               op;
        logic signed [DATA_W-1:0] value;
    } in_item_t;

    typedef struct packed {
        logic [2:0]               status;
        logic signed [DATA_W-1:0] entry_value;
        logic                     last;
    } out_item_t;

    typedef struct packed {
        logic              we;
        logic [AW-1:0]     waddr;
        logic [DATA_W-1:0] wdata;
        logic              re;
        logic [AW-1:0]     raddr;
    } mem_req_t;

endpackage
`default_nettype wire

@@ rtl/cqdbv_ram.sv @@
// Simple dual-port RAM, one write and one registered read port
`default_nettype none
module cqdbv_ram #(
    parameter int WIDTH   = 32,
    parameter int ENTRIES = 32,
    parameter int ABITS   = 5
) (
    input  wire logic             aclk,
    input  wire logic             we,
    input  wire logic [ABITS-1:0] waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [ABITS-1:0] raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [ENTRIES];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

@@ rtl/cqdbv_ctrl.sv @@
// Sequencer: enqueue, search, gap close and listing over the entry RAM
`default_nettype none
module cqdbv_ctrl (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         s_valid,
    output logic                              s_ready,
    input  wire cqdbv_pkg::in_item_t          s_item,
    output logic                              m_valid,
    input  wire logic                         m_ready,
    output cqdbv_pkg::out_item_t              m_item,
    output cqdbv_pkg::mem_req_t               mem_req,
    input  wire logic [cqdbv_pkg::DATA_W-1:0] mem_rdata
);
    import cqdbv_pkg::*;

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SEARCH = 2'd1;
    localparam logic [1:0] S_SHIFT  = 2'd2;
    localparam logic [1:0] S_LIST   = 2'd3;

    logic [1:0]        state_reg, state_next;
    logic [CW-1:0]     count_reg, count_next;
    logic [CW-1:0]     rd_idx_reg, rd_idx_next;
    logic              pend_reg, pend_next;
    logic [AW-1:0]     pidx_reg, pidx_next;
    logic [DATA_W-1:0] req_value_reg, req_value_next;
    logic              out_valid_reg, out_valid_next;
    out_item_t         out_reg, out_next;

    logic          out_free;
    logic          accept;
    logic          issue;
    logic          emit;
    logic          load;
    logic [CW-1:0] count_m1;
    logic          at_end;

    assign out_free = !out_valid_reg || m_ready;
    assign s_ready  = (state_reg == S_IDLE) && out_free;
    assign accept   = s_valid && s_ready;
    assign count_m1 = count_reg - CW'(1);
    assign at_end   = pend_reg && (pidx_reg == count_m1[AW-1:0]);
    assign m_valid  = out_valid_reg;
    assign m_item   = out_reg;

    always_comb begin
        state_next     = state_reg;
        count_next     = count_reg;
        rd_idx_next    = rd_idx_reg;
        pend_next      = pend_reg;
        pidx_next      = pidx_reg;
        req_value_next = req_value_reg;
        out_next       = out_reg;
        load           = 1'b0;
        issue          = 1'b0;
        emit           = 1'b0;
        mem_req        = '0;
        mem_req.raddr  = rd_idx_reg[AW-1:0];
        mem_req.wdata  = mem_rdata;

        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    req_value_next = s_item.value;
                    rd_idx_next    = '0;
                    pend_next      = 1'b0;
                    unique case (s_item.op)
                        OP_ENQ: begin
                            load     = 1'b1;
                            out_next = '{status: ST_STORED, entry_value: s_item.value,
                                         last: 1'b1};
                            if (count_reg == CW'(DEPTH)) begin
                                out_next.status = ST_FULL;
                            end else begin
                                mem_req.we    = 1'b1;
                                mem_req.waddr = count_reg[AW-1:0];
                                mem_req.wdata = s_item.value;
                                count_next    = count_reg + CW'(1);
                            end
                        end
                        OP_REMOVE: begin
                            if (count_reg == '0) begin
                                load     = 1'b1;
                                out_next = '{status: ST_EMPTY, entry_value: s_item.value,
                                             last: 1'b1};
                            end else begin
                                state_next = S_SEARCH;
                            end
                        end
                        OP_LIST: begin
                            if (count_reg == '0) begin
                                load     = 1'b1;
                                out_next = '{status: ST_EMPTY, entry_value: '0, last: 1'b1};
                            end else begin
                                state_next = S_LIST;
                            end
                        end
                        OP_NONE: begin
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_SEARCH: begin
                issue       = rd_idx_reg < count_reg;
                pend_next   = issue;
                pidx_next   = rd_idx_reg[AW-1:0];
                rd_idx_next = rd_idx_reg + CW'(issue);
                out_next    = '{status: ST_REMOVED, entry_value: req_value_reg, last: 1'b1};
                if (pend_reg && (mem_rdata == req_value_reg)) begin
                    if (at_end) begin
                        load       = 1'b1;
                        count_next = count_m1;
                        state_next = S_IDLE;
                    end else begin
                        issue       = 1'b0;
                        pend_next   = 1'b0;
                        rd_idx_next = CW'(pidx_reg) + CW'(1);
                        state_next  = S_SHIFT;
                    end
                end else if (at_end) begin
                    load            = 1'b1;
                    out_next.status = ST_NOTFOUND;
                    state_next      = S_IDLE;
                end
            end
            S_SHIFT: begin
                issue         = rd_idx_reg < count_reg;
                pend_next     = issue;
                pidx_next     = rd_idx_reg[AW-1:0];
                rd_idx_next   = rd_idx_reg + CW'(issue);
                mem_req.we    = pend_reg;
                mem_req.waddr = pidx_reg - AW'(1);
                out_next      = '{status: ST_REMOVED, entry_value: req_value_reg, last: 1'b1};
                if (at_end) begin
                    load       = 1'b1;
                    count_next = count_m1;
                    state_next = S_IDLE;
                end
            end
            S_LIST: begin
                emit        = pend_reg && out_free;
                issue       = (rd_idx_reg < count_reg) && (!pend_reg || emit);
                pend_next   = issue || (pend_reg && !emit);
                rd_idx_next = rd_idx_reg + CW'(issue);
                if (issue) begin
                    pidx_next = rd_idx_reg[AW-1:0];
                end
                if (emit) begin
                    load     = 1'b1;
                    out_next = '{status: ST_LISTED, entry_value: mem_rdata, last: at_end};
                    if (at_end) begin
                        state_next = S_IDLE;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        mem_req.re     = issue;
        out_valid_next = load || (out_valid_reg && !m_ready);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            rd_idx_reg    <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            rd_idx_reg    <= rd_idx_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        pidx_reg      <= pidx_next;
        req_value_reg <= req_value_next;
        out_reg       <= out_next;
    end

endmodule
`default_nettype wire

@@ rtl/circular_queue_delete_by_value_core.sv @@
// Top level: bounded FIFO of signed values with delete by value and listing
//
//   channel  direction  handshake          payload
//   s_       in         s_valid/s_ready    op, value
//   m_       out        m_valid/m_ready    status, entry_value, last
//
// Enqueue, and a remove or list on an empty store, gives its result in the cycle after it is accepted.
// List streams the entries through the RAM read port, one entry per cycle while the result port takes them.
// Remove runs a search pass up to the match, then a gap-close pass over the
// entries behind it, both paced by the one read port.
// Reset (aresetn low, synchronous) empties the store; RAM contents are kept.
// A stalled result port holds listing; a new item waits until the last result leaves.
`default_nettype none
module circular_queue_delete_by_value_core (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire cqdbv_pkg::in_item_t  s_item,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output cqdbv_pkg::out_item_t      m_item
);
    import cqdbv_pkg::*;

    mem_req_t          mem_req;
    logic [DATA_W-1:0] mem_rdata;

    cqdbv_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_item    (s_item),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_item    (m_item),
        .mem_req   (mem_req),
        .mem_rdata (mem_rdata)
    );

    cqdbv_ram #(
        .WIDTH   (DATA_W),
        .ENTRIES (DEPTH),
        .ABITS   (AW)
    ) u_ram (
        .aclk  (aclk),
        .we    (mem_req.we),
        .waddr (mem_req.waddr),
        .wdata (mem_req.wdata),
        .re    (mem_req.re),
        .raddr (mem_req.raddr),
        .rdata (mem_rdata)
    );

endmodule
`default_nettype wire
